[rtl/core/lmt_pkg.sv]
// Shared types, constants and the exp2 root table of the loudness modulation tracker.
package lmt_pkg;

    localparam int          BANDS_DEF   = 128;
    localparam int          QUEUE_DEPTH = 4;
    localparam int          ROOT_STEPS  = 16;
    localparam logic [15:0] RATE_RESET  = 16'd12000;
    localparam logic [15:0] POINT3_Q16  = 16'd19661;
    localparam logic [20:0] POINT3_Q22  = 21'd1258291;

    typedef struct packed {
        logic        oob;
        logic        zero;
        logic [15:0] coef;
        logic [47:0] exc;
        logic [6:0]  band;
    } item_t;

    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] rem;
        r   = 64'd0;
        b   = 64'd1 << 62;
        rem = v;
        for (int i = 0; i < 32; i++) begin
            if (rem >= r + b) begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Successive square roots of two in Q1.30, floor at every step
    function automatic logic [ROOT_STEPS-1:0][31:0] build_roots();
        logic [ROOT_STEPS-1:0][31:0] tab;
        logic [63:0]                 c;
        c = 64'd1 << 31;
        for (int k = 0; k < ROOT_STEPS; k++) begin
            c      = isqrt64(c << 30);
            tab[k] = c[31:0];
        end
        return tab;
    endfunction

    localparam logic [ROOT_STEPS-1:0][31:0] EXP_ROOTS = build_roots();

endpackage

[rtl/core/loudness_modulation_tracker.sv]
// Loudness modulation tracker: per-band loudness, smoothed change and modulation.
// Each word carries a band's excitation and smoothing coefficient; one result word
// comes back per input word, in order. A normal band passes a six-step leading-one
// normaliser, sixteen iterative squarings for log2, sixteen root multiplies for exp2 and a
// 32-step restoring divider for the modulation. Zero excitation goes straight to the change
// step, a band beyond the store to the output. A four-word queue and an output register let
// the input and output sides stall independently of the core. Per-band state is cleared at
// reset through valid bits, so no clearing pass is needed. rate_factor is unsigned Q2.14.
module loudness_modulation_tracker import lmt_pkg::*; #(
    parameter int BANDS = BANDS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // band_index[6:0], excitation[54:7], smoothing_coefficient[70:55]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // result_band[6:0], modulation_value[38:7], average_loudness[70:39]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // rate_factor
);

    logic [15:0] rate_reg;
    logic        q_full;
    logic        q_push;
    item_t       push_item;
    logic        q_pop;
    logic        head_valid;
    item_t       head_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= RATE_RESET;
        end else if (cfg_valid) begin
            rate_reg <= cfg_data;
        end
    end

    lmt_front #(.BANDS(BANDS)) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    lmt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    lmt_core #(.BANDS(BANDS)) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .rate_factor (rate_reg),
        .q_valid     (head_valid),
        .q_item      (head_item),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

[rtl/core/lmt_front.sv]
// Front end: takes input words, unpacks and classifies them for the queue.
module lmt_front import lmt_pkg::*; #(
    parameter int BANDS = BANDS_DEF
) (
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // band_index[6:0], excitation[54:7], smoothing_coefficient[70:55]
    input  logic        q_full,
    output logic        q_push,
    output item_t       q_item
);

    always_comb begin
        q_item.band = s_tdata[6:0];
        q_item.exc  = s_tdata[54:7];
        q_item.coef = s_tdata[70:55];
        // flag bands beyond the store and silent bands
        q_item.oob  = int'(s_tdata[6:0]) >= BANDS;
        q_item.zero = s_tdata[54:7] == 48'd0;
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

[rtl/core/lmt_queue.sv]
// Short queue of classified words between the front end and the core.
module lmt_queue import lmt_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output item_t head_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t          slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    assign full       = count_reg == CW'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_item  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/core/lmt_core.sv]
// Back end: loudness, change, smoothing and modulation per band, with output register.
module lmt_core import lmt_pkg::*; #(
    parameter int BANDS = BANDS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] rate_factor,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata
);

    localparam int AW = (BANDS > 1) ? $clog2(BANDS) : 1;

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b000000000001,
        ST_NORM  = 12'b000000000010,
        ST_LOG   = 12'b000000000100,
        ST_SCALE = 12'b000000001000,
        ST_EXP   = 12'b000000010000,
        ST_SHIFT = 12'b000000100000,
        ST_CHG   = 12'b000001000000,
        ST_SMC   = 12'b000010000000,
        ST_SML   = 12'b000100000000,
        ST_MUL   = 12'b001000000000,
        ST_DIV   = 12'b010000000000,
        ST_DONE  = 12'b100000000000
    } state_t;

    state_t         state_reg, state_next;
    logic [4:0]     cnt_reg;
    logic [6:0]     band_reg;
    logic [15:0]    coef_reg;
    logic [47:0]    w_reg;
    logic [5:0]     z_reg;
    logic [31:0]    m_reg;
    logic [15:0]    frac_reg;
    logic [22:0]    v_reg;
    logic [31:0]    l_reg;
    logic [31:0]    chg_reg;
    logic [31:0]    sc_reg;
    logic [31:0]    sl_reg;
    logic [32:0]    den_reg;
    logic [32:0]    rem_reg;
    logic [31:0]    q_reg;
    logic           sat_reg;
    logic           out_valid_reg;
    logic [71:0]    out_data_reg;

    logic [31:0]    prior_mem [BANDS];
    logic [31:0]    sl_mem    [BANDS];
    logic [31:0]    sc_mem    [BANDS];
    logic [BANDS-1:0] vld_reg;
    logic [31:0]    prior_rd_reg;
    logic [31:0]    sl_rd_reg;
    logic [31:0]    sc_rd_reg;
    logic           vld_rd_reg;

    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    logic           out_load;

    // datapath terms
    logic [5:0]     nshift;
    logic [47:0]    w_nx;
    logic [5:0]     z_nx;
    logic [61:0]    sq;
    logic [31:0]    msq;
    logic [22:0]    l2;
    logic [39:0]    t_scaled;
    logic [63:0]    exp_prod;
    logic [31:0]    exp_m;
    logic [7:0]     sh;
    logic [7:0]     nsh;
    logic [3:0]     lsh;
    logic [63:0]    lres;
    logic [31:0]    prior_v;
    logic [31:0]    sl_old;
    logic [31:0]    sc_old;
    logic [31:0]    dl;
    logic [47:0]    chg_p;
    logic [16:0]    coef_inv;
    logic [49:0]    smc_r;
    logic [49:0]    sml_r;
    logic [32:0]    den_c;
    logic [53:0]    num_c;
    logic [33:0]    rem2;
    logic           qbit;

    assign rd_addr  = AW'(q_item.band);
    assign wr_addr  = AW'(band_reg);
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        // normaliser: halve the shift step each cycle
        nshift = 6'd32 >> cnt_reg[2:0];
        if ((w_reg >> (48 - int'(nshift))) == 48'd0) begin
            w_nx = w_reg << nshift;
            z_nx = z_reg + nshift;
        end else begin
            w_nx = w_reg;
            z_nx = z_reg;
        end

        sq  = m_reg[30:0] * m_reg[30:0];
        msq = sq[61:30];

        l2       = {7'd31 - {1'b0, z_reg}, frac_reg};
        t_scaled = {{17{l2[22]}}, l2} * 40'(POINT3_Q16)
                   + (40'd1 << 37) + 40'h8000;

        exp_prod = 64'(m_reg) * 64'(EXP_ROOTS[cnt_reg[3:0]]);
        exp_m    = 32'((exp_prod + (64'd1 << 29)) >> 30);

        sh  = {1'b0, v_reg[22:16]} - 8'd40;
        nsh = 8'd0 - sh;
        lsh = (sh > 8'd8) ? 4'd8 : sh[3:0];
        if (!sh[7]) begin
            lres = 64'(m_reg) << lsh;
        end else if (nsh < 8'd40) begin
            lres = (64'(m_reg) + (64'd1 << (nsh - 8'd1))) >> nsh;
        end else begin
            lres = 64'd0;
        end

        prior_v = vld_rd_reg ? prior_rd_reg : 32'd0;
        sl_old  = vld_rd_reg ? sl_rd_reg    : 32'd0;
        sc_old  = vld_rd_reg ? sc_rd_reg    : 32'd0;
        dl      = (l_reg >= prior_v) ? l_reg - prior_v : prior_v - l_reg;
        chg_p   = 48'(dl) * 48'(rate_factor) + 48'h2000;

        coef_inv = 17'd65536 - 17'(coef_reg);
        smc_r    = 50'(coef_reg) * 50'(sc_old) + 50'(coef_inv) * 50'(chg_reg) + 50'h8000;
        sml_r    = 50'(coef_reg) * 50'(sl_old) + 50'(coef_inv) * 50'(l_reg) + 50'h8000;

        den_c = 33'(POINT3_Q22) + 33'(sl_reg);
        num_c = 54'(sc_reg) * 54'(POINT3_Q22) + 54'(den_c >> 1);

        rem2 = {rem_reg, q_reg[31]};
        qbit = rem2 >= {1'b0, den_reg};
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (q_item.oob) begin
                        state_next = ST_DONE;
                    end else if (q_item.zero) begin
                        state_next = ST_CHG;
                    end else begin
                        state_next = ST_NORM;
                    end
                end
            end
            ST_NORM:  state_next = (cnt_reg == 5'd5)  ? ST_LOG   : ST_NORM;
            ST_LOG:   state_next = (cnt_reg == 5'd15) ? ST_SCALE : ST_LOG;
            ST_SCALE: state_next = ST_EXP;
            ST_EXP:   state_next = (cnt_reg == 5'd15) ? ST_SHIFT : ST_EXP;
            ST_SHIFT: state_next = ST_CHG;
            ST_CHG:   state_next = ST_SMC;
            ST_SMC:   state_next = ST_SML;
            ST_SML:   state_next = ST_MUL;
            ST_MUL:   state_next = ST_DIV;
            ST_DIV:   state_next = (cnt_reg == 5'd31) ? ST_DONE : ST_DIV;
            ST_DONE:  state_next = out_load ? ST_IDLE : ST_DONE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // per-band stores: registered read on pop, write back after smoothing
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            prior_rd_reg <= prior_mem[rd_addr];
            sl_rd_reg    <= sl_mem[rd_addr];
            sc_rd_reg    <= sc_mem[rd_addr];
        end
        if (state_reg == ST_SML) begin
            prior_mem[wr_addr] <= l_reg;
            sl_mem[wr_addr]    <= sml_r[47:16];
            sc_mem[wr_addr]    <= sc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            vld_reg       <= '0;
            vld_rd_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (q_pop) begin
                vld_rd_reg <= vld_reg[rd_addr];
            end
            if (state_reg == ST_SML) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                band_reg <= q_item.band;
                coef_reg <= q_item.coef;
                w_reg    <= q_item.exc;
                z_reg    <= 6'd0;
                cnt_reg  <= 5'd0;
                l_reg    <= 32'd0;
                sl_reg   <= 32'd0;
                q_reg    <= 32'd0;
                sat_reg  <= 1'b0;
            end
            ST_NORM: begin
                w_reg   <= w_nx;
                z_reg   <= z_nx;
                m_reg   <= {1'b0, w_nx[47:17]};
                cnt_reg <= (cnt_reg == 5'd5) ? 5'd0 : cnt_reg + 5'd1;
            end
            ST_LOG: begin
                frac_reg <= {frac_reg[14:0], msq[31]};
                m_reg    <= msq[31] ? (msq >> 1) : msq;
                cnt_reg  <= (cnt_reg == 5'd15) ? 5'd0 : cnt_reg + 5'd1;
            end
            ST_SCALE: begin
                v_reg   <= t_scaled[38:16];
                m_reg   <= 32'h4000_0000;
                cnt_reg <= 5'd0;
            end
            ST_EXP: begin
                if (v_reg[4'd15 - cnt_reg[3:0]]) begin
                    m_reg <= exp_m;
                end
                cnt_reg <= (cnt_reg == 5'd15) ? 5'd0 : cnt_reg + 5'd1;
            end
            ST_SHIFT: begin
                l_reg <= (lres[63:32] != 32'd0) ? 32'hFFFF_FFFF : lres[31:0];
            end
            ST_CHG: begin
                chg_reg <= (chg_p[47:46] != 2'd0) ? 32'hFFFF_FFFF : chg_p[45:14];
            end
            ST_SMC: begin
                sc_reg <= smc_r[47:16];
            end
            ST_SML: begin
                sl_reg <= sml_r[47:16];
            end
            ST_MUL: begin
                den_reg <= den_c;
                rem_reg <= 33'(num_c[53:32]);
                q_reg   <= num_c[31:0];
                // quotient reaches 2^32 when the upper part already holds the divisor
                sat_reg <= 33'(num_c[53:32]) >= den_c;
                cnt_reg <= 5'd0;
            end
            ST_DIV: begin
                rem_reg <= qbit ? 33'(rem2 - {1'b0, den_reg}) : rem2[32:0];
                q_reg   <= {q_reg[30:0], qbit};
                cnt_reg <= cnt_reg + 5'd1;
            end
            ST_DONE: begin
                if (out_load) begin
                    out_data_reg <= {1'b0, sl_reg, sat_reg ? 32'hFFFF_FFFF : q_reg, band_reg};
                end
            end
            default: begin
                cnt_reg <= 5'd0;
            end
        endcase
    end

endmodule
